### rtl/core/lennard_jones_pair_energy_accumulator_unit_defines.svh
// assertion macros for the lennard-jones pair energy accumulator
`ifndef LENNARD_JONES_PAIR_ENERGY_ACCUMULATOR_UNIT_DEFINES_SVH
`define LENNARD_JONES_PAIR_ENERGY_ACCUMULATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LJPE_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("ljpe check failed");
`define LJPE_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("ljpe sequence check failed");
`else
`define LJPE_ASSERT_IMP(lbl, cond, prop)
`define LJPE_ASSERT_NXT(lbl, cond, prop)
`endif
`endif

### rtl/core/ljpe_pkg.sv
// shared types and constants for the lennard-jones pair energy accumulator
package ljpe_pkg;
  localparam int FRACTION_BITS = 24;
  localparam int SUM_WIDTH = 48;
  localparam int OP_W = 64;
  localparam int EXT_W = 66;
  localparam int DIV_N = (3 * FRACTION_BITS + 1 > OP_W) ? 3 * FRACTION_BITS + 1 : OP_W;
  localparam logic [OP_W-1:0] CAP63 = {1'b0, {(OP_W-1){1'b1}}};
  localparam logic [OP_W-1:0] EPS_D2 =
    ((64'd1 << (2 * FRACTION_BITS)) + 64'd500000000) / 64'd1000000000;
  localparam logic signed [EXT_W-1:0] SUM_MAX_X =
    (EXT_W'(66'sd1) <<< (SUM_WIDTH - 1)) - EXT_W'(66'sd1);
  localparam logic signed [EXT_W-1:0] SUM_MIN_X = -SUM_MAX_X - EXT_W'(66'sd1);

  localparam logic [30:0] BOX_RESET = 31'd268435456;
  localparam logic [30:0] CUT_RESET = 31'd41943040;

  typedef enum logic [2:0] {
    REG_BOX  = 3'd0,
    REG_CUT  = 3'd1,
    REG_EAC  = 3'd2,
    REG_TAIL = 3'd3,
    REG_PTOT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [30:0]        box_edge;
    logic [30:0]        cutoff_distance;
    logic signed [31:0] energy_at_cutoff;
    logic signed [31:0] tail_error;
    logic [15:0]        particle_total;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;
endpackage

### rtl/core/ljpe_cfg.sv
// apb configuration register bank
module ljpe_cfg
  import ljpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);
  logic wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_edge <= BOX_RESET;
      cfg.cutoff_distance <= CUT_RESET;
      cfg.energy_at_cutoff <= '0;
      cfg.tail_error <= '0;
      cfg.particle_total <= '0;
    end else if (wr) begin
      case (idx)
        REG_BOX:  cfg.box_edge <= pwdata[30:0];
        REG_CUT:  cfg.cutoff_distance <= pwdata[30:0];
        REG_EAC:  cfg.energy_at_cutoff <= $signed(pwdata);
        REG_TAIL: cfg.tail_error <= $signed(pwdata);
        REG_PTOT: cfg.particle_total <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BOX:  prdata = {1'b0, cfg.box_edge};
      REG_CUT:  prdata = {1'b0, cfg.cutoff_distance};
      REG_EAC:  prdata = cfg.energy_at_cutoff;
      REG_TAIL: prdata = cfg.tail_error;
      REG_PTOT: prdata = {16'd0, cfg.particle_total};
      default:  prdata = '0;
    endcase
  end
endmodule

### rtl/core/ljpe_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module ljpe_div
  import ljpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [DIV_N-1:0] dividend,
  input  logic [OP_W-1:0]  divisor,
  output logic [DIV_N-1:0] quot,
  output logic [OP_W-1:0]  rem,
  output unit_st_t         st
);
  localparam int CW = $clog2(DIV_N + 1);
  logic [CW-1:0]   cnt;
  logic [OP_W-1:0] den;
  logic [OP_W:0]   trial;
  logic            fits;

  assign trial = {rem, quot[DIV_N-1]};
  assign fits = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      st.busy <= 1'b0;
      st.done <= 1'b0;
      cnt <= '0;
    end else begin
      if (go) begin
        st.busy <= 1'b1;
        st.done <= 1'b0;
        cnt <= CW'(DIV_N);
      end else if (st.busy) begin
        cnt <= cnt - CW'(1);
        st.done <= (cnt == CW'(1));
        if (cnt == CW'(1)) st.busy <= 1'b0;
      end else begin
        st.done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quot <= dividend;
      den <= divisor;
    end else if (st.busy) begin
      rem <= fits ? OP_W'(trial - {1'b0, den}) : trial[OP_W-1:0];
      quot <= {quot[DIV_N-2:0], fits};
    end
  end
endmodule

### rtl/core/ljpe_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module ljpe_mul
  import ljpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [OP_W-1:0]   a,
  input  logic [OP_W-1:0]   b,
  output logic [2*OP_W-1:0] prod,
  output unit_st_t          st
);
  localparam int CW = $clog2(OP_W + 1);
  logic [CW-1:0]   cnt;
  logic [OP_W-1:0] mcand;
  logic [OP_W-1:0] hi;
  logic [OP_W-1:0] lo;
  logic [OP_W:0]   sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      st.busy <= 1'b0;
      st.done <= 1'b0;
      cnt <= '0;
    end else begin
      if (go) begin
        st.busy <= 1'b1;
        st.done <= 1'b0;
        cnt <= CW'(OP_W);
      end else if (st.busy) begin
        cnt <= cnt - CW'(1);
        st.done <= (cnt == CW'(1));
        if (cnt == CW'(1)) st.busy <= 1'b0;
      end else begin
        st.done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hi <= '0;
      lo <= b;
      mcand <= a;
    end else if (st.busy) begin
      hi <= sum[OP_W:1];
      lo <= {sum[0], lo[OP_W-1:1]};
    end
  end
endmodule

### rtl/core/lennard_jones_pair_energy_accumulator_unit.sv
// lennard-jones pair energy accumulator top level: sequencer and accumulators
// one pair in work at a time, set by the shared bit-serial divider and multiplier
// pair path: a skipped pair goes straight to S_FIN; others fold and square each axis,
// test against the squared cutoff, and within it take the reciprocal, three products and the sums
// a last pair's word is registered in S_EMIT, after S_TAIL when the tail applies, once the output is free
// synchronous reset clears sums, sequencer and output word
`include "lennard_jones_pair_energy_accumulator_unit_defines.svh"
module lennard_jones_pair_energy_accumulator_unit
  import ljpe_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          ref_x,
  input  logic signed [31:0]          ref_y,
  input  logic signed [31:0]          ref_z,
  input  logic signed [31:0]          other_x,
  input  logic signed [31:0]          other_y,
  input  logic signed [31:0]          other_z,
  input  logic                        skip_pair,
  input  logic                        last_pair,
  input  logic                        apply_tail,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SUM_WIDTH-1:0] total_energy,
  output logic signed [SUM_WIDTH-1:0] total_virial
);
  localparam logic signed [EXT_W-1:0] E_HI = SUM_MAX_X / 4;
  localparam logic signed [EXT_W-1:0] E_LO = SUM_MIN_X / 4;
  localparam logic signed [EXT_W-1:0] V_HI = SUM_MAX_X / 48;
  localparam logic signed [EXT_W-1:0] V_LO = SUM_MIN_X / 48;
  localparam logic [DIV_N-1:0] RECIP_NUM = DIV_N'(1) << (3 * FRACTION_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP_GO, S_WRAP_WAIT, S_SQ_WAIT, S_CUT_WAIT, S_RECIP_WAIT,
    S_M1, S_M2, S_M3, S_PAIR1, S_PAIR2, S_PAIR3, S_FIN, S_TAIL, S_EMIT
  } state_t;

  function automatic logic signed [SUM_WIDTH-1:0] sat_w(input logic signed [EXT_W-1:0] x);
    logic signed [EXT_W-1:0] y;
    if (x > SUM_MAX_X) y = SUM_MAX_X;
    else if (x < SUM_MIN_X) y = SUM_MIN_X;
    else y = x;
    return y[SUM_WIDTH-1:0];
  endfunction

  function automatic logic [OP_W-1:0] sat_q(input logic [2*OP_W-1:0] p);
    if (|p[2*OP_W-1:FRACTION_BITS+OP_W-1]) return CAP63;
    return {1'b0, p[FRACTION_BITS+OP_W-2:FRACTION_BITS]};
  endfunction

  cfg_t     cfg;
  unit_st_t div_st;
  unit_st_t mul_st;
  logic [DIV_N-1:0]  div_quot;
  logic [OP_W-1:0]   div_rem;
  logic [2*OP_W-1:0] mul_prod;

  state_t state;
  logic [1:0] axis;
  logic signed [31:0] ra [3];
  logic signed [31:0] oa [3];
  logic last, tail;
  logic div_go, mul_go;
  logic [DIV_N-1:0] div_num;
  logic [OP_W-1:0] div_den, mul_a, mul_b;
  logic [OP_W-1:0] d2, u, u3, u6;
  logic signed [SUM_WIDTH-1:0] pe, pv, es, vs;
  logic signed [48:0] tprod;

  logic [30:0] len;
  logic signed [32:0] d_ax;
  logic [32:0] mag;
  logic signed [34:0] rsig, rmag;
  logic [34:0] rabs;
  logic [OP_W-1:0] d2f;
  logic signed [EXT_W-1:0] de, dv;
  logic out_free;

  assign len = (cfg.box_edge == '0) ? 31'd1 : cfg.box_edge;
  assign d_ax = 33'(ra[axis]) - 33'(oa[axis]);
  assign mag = d_ax[32] ? 33'(-d_ax) : 33'(d_ax);
  assign rsig = $signed({2'b0, div_rem[32:0]}) - $signed({4'b0, len});
  assign rmag = rsig >>> 1;
  assign rabs = rmag[34] ? 35'(-rmag) : 35'(rmag);
  assign d2f = (d2 < EPS_D2) ? EPS_D2 : d2;
  assign de = $signed({2'b0, u6}) - $signed({2'b0, u3});
  assign dv = $signed({2'b0, u6}) - $signed({3'b0, u3[OP_W-1:1]});
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  ljpe_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ljpe_div u_div (
    .clk, .rst, .go(div_go), .dividend(div_num), .divisor(div_den),
    .quot(div_quot), .rem(div_rem), .st(div_st)
  );

  ljpe_mul u_mul (
    .clk, .rst, .go(mul_go), .a(mul_a), .b(mul_b), .prod(mul_prod), .st(mul_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis <= '0;
      div_go <= 1'b0;
      mul_go <= 1'b0;
      es <= '0;
      vs <= '0;
      out_valid <= 1'b0;
      total_energy <= '0;
      total_virial <= '0;
    end else begin
      div_go <= (state == S_WRAP_GO) ||
                (state == S_CUT_WAIT && mul_st.done && d2f <= mul_prod[OP_W-1:0]);
      mul_go <= (state == S_WRAP_WAIT && div_st.done) ||
                (state == S_SQ_WAIT && mul_st.done && axis == 2'd2) ||
                (state == S_RECIP_WAIT && div_st.done) ||
                ((state == S_M1 || state == S_M2) && mul_st.done);
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ra[0] <= ref_x;
            ra[1] <= ref_y;
            ra[2] <= ref_z;
            oa[0] <= other_x;
            oa[1] <= other_y;
            oa[2] <= other_z;
            last <= last_pair;
            tail <= apply_tail;
            axis <= '0;
            d2 <= '0;
            state <= skip_pair ? S_FIN : S_WRAP_GO;
          end
        end
        S_WRAP_GO: begin
          div_num <= DIV_N'({mag, 1'b0} + {2'b0, len});
          div_den <= OP_W'({len, 1'b0});
          state <= S_WRAP_WAIT;
        end
        S_WRAP_WAIT: begin
          if (div_st.done) begin
            mul_a <= OP_W'(rabs);
            mul_b <= OP_W'(rabs);
            state <= S_SQ_WAIT;
          end
        end
        S_SQ_WAIT: begin
          if (mul_st.done) begin
            d2 <= d2 + mul_prod[OP_W-1:0];
            if (axis == 2'd2) begin
              mul_a <= OP_W'(cfg.cutoff_distance);
              mul_b <= OP_W'(cfg.cutoff_distance);
              state <= S_CUT_WAIT;
            end else begin
              axis <= axis + 2'd1;
              state <= S_WRAP_GO;
            end
          end
        end
        S_CUT_WAIT: begin
          if (mul_st.done) begin
            if (d2f <= mul_prod[OP_W-1:0]) begin
              div_num <= RECIP_NUM;
              div_den <= d2f;
              state <= S_RECIP_WAIT;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_RECIP_WAIT: begin
          if (div_st.done) begin
            if (|div_quot[DIV_N-1:OP_W-1]) begin
              u <= CAP63;
              mul_a <= CAP63;
              mul_b <= CAP63;
            end else begin
              u <= OP_W'(div_quot[OP_W-2:0]);
              mul_a <= OP_W'(div_quot[OP_W-2:0]);
              mul_b <= OP_W'(div_quot[OP_W-2:0]);
            end
            state <= S_M1;
          end
        end
        S_M1: begin
          if (mul_st.done) begin
            mul_a <= sat_q(mul_prod);
            mul_b <= u;
            state <= S_M2;
          end
        end
        S_M2: begin
          if (mul_st.done) begin
            u3 <= sat_q(mul_prod);
            mul_a <= sat_q(mul_prod);
            mul_b <= sat_q(mul_prod);
            state <= S_M3;
          end
        end
        S_M3: begin
          if (mul_st.done) begin
            u6 <= sat_q(mul_prod);
            state <= S_PAIR1;
          end
        end
        S_PAIR1: begin
          if (de > E_HI) pe <= SUM_MAX_X[SUM_WIDTH-1:0];
          else if (de < E_LO) pe <= SUM_MIN_X[SUM_WIDTH-1:0];
          else pe <= SUM_WIDTH'(de <<< 2);
          if (dv > V_HI) pv <= SUM_MAX_X[SUM_WIDTH-1:0];
          else if (dv < V_LO) pv <= SUM_MIN_X[SUM_WIDTH-1:0];
          else pv <= SUM_WIDTH'((dv <<< 5) + (dv <<< 4));
          state <= S_PAIR2;
        end
        S_PAIR2: begin
          if (u6 == CAP63) begin
            pe <= SUM_MAX_X[SUM_WIDTH-1:0];
            pv <= SUM_MAX_X[SUM_WIDTH-1:0];
          end else begin
            pe <= sat_w(EXT_W'(pe) - EXT_W'(cfg.energy_at_cutoff));
          end
          state <= S_PAIR3;
        end
        S_PAIR3: begin
          es <= sat_w(EXT_W'(es) + EXT_W'(pe));
          vs <= sat_w(EXT_W'(vs) + EXT_W'(pv));
          state <= S_FIN;
        end
        S_FIN: begin
          tprod <= $signed({1'b0, cfg.particle_total}) * cfg.tail_error;
          if (!last) state <= S_IDLE;
          else if (tail) state <= S_TAIL;
          else state <= S_EMIT;
        end
        S_TAIL: begin
          es <= sat_w(EXT_W'(es) + EXT_W'(tprod));
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            total_energy <= es;
            total_virial <= vs;
            out_valid <= 1'b1;
            es <= '0;
            vs <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LJPE_ASSERT_IMP(a_units_exclusive, div_st.busy, !mul_st.busy)
  `LJPE_ASSERT_NXT(a_skip_path, in_valid && !in_stall && skip_pair, state == S_FIN)
  `LJPE_ASSERT_NXT(a_emit_clears, state == S_EMIT && out_free, out_valid && es == '0 && vs == '0)
endmodule

### dv/tb_top.sv
// testbench for the lennard-jones pair energy accumulator: directed tables, then random pairs
`timescale 1ns / 100ps
module tb_top;
  import ljpe_pkg::*;

  typedef struct {
    logic signed [31:0] rx, ry, rz, ox, oy, oz;
    bit skip, last, tail;
  } pair_t;

  typedef struct {
    pair_t  p;
    bit     typed;
    longint e, v;
  } row_t;

  typedef struct {
    bit     typed;
    longint e, v;
  } typed_t;

  localparam longint SUM_HI = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam logic signed [31:0] ONE = 32'sh0100_0000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] ref_x = 0, ref_y = 0, ref_z = 0, other_x = 0, other_y = 0, other_z = 0;
  logic skip_pair = 0, last_pair = 0, apply_tail = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [SUM_WIDTH-1:0] total_energy, total_virial;

  logic [30:0] box_q = BOX_RESET;
  logic [30:0] cut_q = CUT_RESET;
  longint eac_q = 0, tail_q = 0, ptot_q = 0;
  longint energy_acc = 0, virial_acc = 0;

  longint energy_q[$], virial_q[$];
  typed_t typed_q[$];
  row_t table_q[$];
  int mismatches = 0;
  int taken = 0;
  int burst_left = 0;
  logic hold_off = 0;

  always #5 clk = ~clk;

  lennard_jones_pair_energy_accumulator_unit i_dut (.*);

  function automatic longint clip(longint x);
    return x > SUM_HI ? SUM_HI : (x < SUM_LO ? SUM_LO : x);
  endfunction

  function automatic longint fold(longint a, longint b, longint len);
    longint d, mag, q;
    d = a - b;
    mag = d < 0 ? -d : d;
    q = (2 * mag + len) / (2 * len);
    return d < 0 ? d + q * len : d - q * len;
  endfunction

  function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> FRACTION_BITS;
    return p > {64'd0, CAP63} ? CAP63 : p[63:0];
  endfunction

  function automatic logic [63:0] recip(logic [63:0] d);
    logic [127:0] q;
    q = (128'd1 << (3 * FRACTION_BITS)) / {64'd0, d};
    return q > {64'd0, CAP63} ? CAP63 : q[63:0];
  endfunction

  // accumulate one pair; returns 1 when the sums go out
  function automatic bit pair_energy(pair_t p, output longint e, output longint v);
    longint len, x, y, z, de, dv, pe, pv;
    logic [63:0] d2, u, u3, u6;
    if (!p.skip) begin
      len = box_q == 0 ? 1 : longint'(box_q);
      x = fold(p.rx, p.ox, len);
      y = fold(p.ry, p.oy, len);
      z = fold(p.rz, p.oz, len);
      d2 = x * x + y * y + z * z;
      if (d2 < EPS_D2) d2 = EPS_D2;
      if (d2 <= {33'd0, cut_q} * {33'd0, cut_q}) begin
        u = recip(d2);
        u3 = mulq(mulq(u, u), u);
        u6 = mulq(u3, u3);
        if (u6 == CAP63) begin
          pe = SUM_HI;
          pv = SUM_HI;
        end else begin
          de = longint'(u6) - longint'(u3);
          dv = longint'(u6) - longint'(u3 >> 1);
          pe = clip(clip(4 * clip(de)) - eac_q);
          pv = clip(48 * clip(dv));
        end
        energy_acc = clip(energy_acc + pe);
        virial_acc = clip(virial_acc + pv);
      end
    end
    if (!p.last) return 0;
    if (p.tail) energy_acc = clip(energy_acc + ptot_q * tail_q);
    e = energy_acc;
    v = virial_acc;
    energy_acc = 0;
    virial_acc = 0;
    return 1;
  endfunction

  always @(posedge clk) begin
    longint e, v;
    typed_t t;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        taken++;
        if (pair_energy('{ref_x, ref_y, ref_z, other_x, other_y, other_z,
                           skip_pair, last_pair, apply_tail}, e, v)) begin
          if (typed_q.size() != 0) begin
            t = typed_q.pop_front();
            if (t.typed) begin
              e = t.e;
              v = t.v;
            end
          end
          energy_q.push_back(e);
          virial_q.push_back(v);
        end
      end
      if (out_valid && !out_stall) begin
        if (energy_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: energy %0d virial %0d",
                                         total_energy, total_virial);
        end else begin
          e = energy_q.pop_front();
          v = virial_q.pop_front();
          if (longint'(total_energy) != e || longint'(total_virial) != v) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: energy exp %0d got %0d, virial exp %0d got %0d",
                       e, total_energy, v, total_virial);
          end
        end
      end
    end
  end

  // receiver stall pattern, stepping through four stall modes in turn
  always @(posedge clk) begin
    int mode;
    mode = ($time / 640) % 4;
    case (mode)
      0: out_stall <= hold_off;
      1: out_stall <= hold_off || ($urandom_range(0, 1) == 1);
      2: out_stall <= hold_off || ($urandom_range(0, 9) != 0);
      default: out_stall <= hold_off || ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    wait (taken >= 400);
    @(posedge clk);
    hold_off <= 1;
    repeat (30000) @(posedge clk);
    hold_off <= 0;
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_BOX: box_q = val[30:0];
      REG_CUT: cut_q = val[30:0];
      REG_EAC: eac_q = longint'(signed'(val));
      REG_TAIL: tail_q = longint'(signed'(val));
      REG_PTOT: ptot_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] box, logic [31:0] cut, logic [31:0] eac,
                         logic [31:0] tail, logic [31:0] ptot);
    write_reg(REG_BOX, box);
    write_reg(REG_CUT, cut);
    write_reg(REG_EAC, eac);
    write_reg(REG_TAIL, tail);
    write_reg(REG_PTOT, ptot);
  endtask

  task automatic offer(pair_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1;
    ref_x <= p.rx;
    ref_y <= p.ry;
    ref_z <= p.rz;
    other_x <= p.ox;
    other_y <= p.oy;
    other_z <= p.oz;
    skip_pair <= p.skip;
    last_pair <= p.last;
    apply_tail <= p.tail;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    while (energy_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  function automatic row_t row(logic signed [31:0] rx, ry, rz, ox, oy, oz,
                               bit skip, last, tail, bit typed = 0,
                               longint e = 0, longint v = 0);
    row_t r;
    r.p = '{rx, ry, rz, ox, oy, oz, skip, last, tail};
    r.typed = typed;
    r.e = e;
    r.v = v;
    return r;
  endfunction

  function automatic logic signed [31:0] near(logic signed [31:0] a, int span);
    return a + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic pair_t random_pair(int box);
    pair_t p;
    int k;
    k = $urandom_range(0, 19);
    p.rx = $urandom;
    p.ry = $urandom;
    p.rz = $urandom;
    if (k < 16) begin
      // neighbour within a few units, sometimes shifted by whole boxes
      p.ox = near(p.rx, 3 * ONE) + (k < 4 ? box * $signed($urandom_range(0, 4) - 2) : 0);
      p.oy = near(p.ry, 3 * ONE);
      p.oz = near(p.rz, 3 * ONE);
    end else if (k < 17) begin
      p.ox = p.rx;
      p.oy = p.ry;
      p.oz = near(p.rz, 64);
    end else begin
      p.ox = $urandom;
      p.oy = $urandom;
      p.oz = $urandom;
    end
    p.skip = $urandom_range(0, 9) == 0;
    p.last = $urandom_range(0, 7) == 0;
    p.tail = $urandom_range(0, 1);
    return p;
  endfunction

  initial begin
    logic signed [31:0] mx, mn;
    typed_t t;
    pair_t p;
    int box;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings: box 16, cutoff 2.5
    table_q.push_back(row(0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 0, 0));
    table_q.push_back(row(ONE, ONE, ONE, ONE, ONE, ONE, 0, 1, 0, 1, SUM_HI, SUM_HI));
    table_q.push_back(row(0, 0, 0, 3 * ONE, 0, 0, 0, 1, 0, 1, 0, 0));
    table_q.push_back(row(0, 0, 0, ONE, 0, 0, 0, 1, 0, 1, 0, 48 * 64'sd8388608));
    table_q.push_back(row(mx, mx, mx, mn, mn, mn, 0, 0, 0));
    table_q.push_back(row(32'sh07E6_6666, 0, 0, -32'sh07E6_6666, 0, 0, 0, 0, 1));
    table_q.push_back(row(8 * ONE, 0, 0, -8 * ONE, ONE, 0, 0, 0, 0));
    table_q.push_back(row(ONE + ONE / 8, 0, 0, 0, 0, 0, 0, 0, 0));
    table_q.push_back(row(mn, mn, mn, mx, mx, mx, 0, 1, 1));
    foreach (table_q[i]) begin
      if (table_q[i].p.last) typed_q.push_back('{table_q[i].typed, table_q[i].e, table_q[i].v});
      offer(table_q[i].p);
    end
    drain();

    // box of zero acts as one, widest cutoff, extreme shift and tail
    set_all(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF);
    table_q.delete();
    table_q.push_back(row(0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 65535 * -64'sd2147483648, 0));
    table_q.push_back(row(ONE / 4, 0, 0, 0, 0, 0, 0, 0, 1));
    table_q.push_back(row(mx, mn, 0, mn, mx, 0, 0, 1, 0));
    table_q.push_back(row(ONE / 2, ONE / 2, ONE / 2, 0, 0, 0, 0, 1, 1));
    foreach (table_q[i]) begin
      if (table_q[i].p.last) typed_q.push_back('{table_q[i].typed, table_q[i].e, table_q[i].v});
      offer(table_q[i].p);
    end
    drain();

    // largest box, zero cutoff: nothing counts
    set_all(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    table_q.delete();
    table_q.push_back(row(ONE, 0, 0, ONE, 0, 0, 0, 1, 1, 1, 0, 0));
    table_q.push_back(row(mx, mx, mx, mn, mn, mn, 0, 1, 0, 1, 0, 0));
    foreach (table_q[i]) begin
      if (table_q[i].p.last) typed_q.push_back('{table_q[i].typed, table_q[i].e, table_q[i].v});
      offer(table_q[i].p);
    end
    drain();

    // random phases with fresh settings
    for (int ph = 0; ph < 5; ph++) begin
      box = (ph == 4) ? $urandom_range(1, 32'h7FFF_FFFF) : $urandom_range(4 * ONE, 32 * ONE);
      set_all(box, $urandom_range(ONE / 2, 4 * ONE), $urandom_range(0, 1) ? $urandom
              : $urandom_range(0, 32'h0100_0000), $urandom, $urandom_range(0, 16'hFFFF));
      for (int n = 0; n < 208; n++) begin
        p = random_pair(box);
        if (n == 207) p.last = 1;
        offer(p);
      end
      drain();
    end

    if (mismatches == 0 && typed_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/ljpe_pkg.sv
rtl/core/ljpe_cfg.sv
rtl/core/ljpe_div.sv
rtl/core/ljpe_mul.sv
rtl/core/lennard_jones_pair_energy_accumulator_unit.sv
dv/tb_top.sv
